// ===== design/tbcc_pkg.sv =====
`default_nettype none

package tbcc_pkg;

  // store sizes
  localparam int TEXT_DEPTH = 256;
  localparam int CLIP_DEPTH = 256;
  localparam int MAX_DEPTH  = (TEXT_DEPTH > CLIP_DEPTH) ? TEXT_DEPTH : CLIP_DEPTH;

  // field widths
  localparam int POS_W  = 9;
  localparam int BYTE_W = 8;
  localparam int STEP_W = $clog2(MAX_DEPTH + 1);
  localparam int CNT_W  = (STEP_W > POS_W) ? STEP_W : POS_W;

  typedef enum logic [2:0] {
    OP_LEFT   = 3'd0,
    OP_RIGHT  = 3'd1,
    OP_INSERT = 3'd2,
    OP_CUT    = 3'd3,
    OP_COPY   = 3'd4,
    OP_PASTE  = 3'd5,
    OP_READ   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // what a cell takes in the next cycle
  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_PUSH = 2'd1,
    CM_POP  = 2'd2
  } cell_mode_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_BUSY = 2'd1,
    S_OUT  = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [BYTE_W-1:0] char_in;
    logic [POS_W-1:0]  count;
    logic [7:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  clip_length;
    logic [BYTE_W-1:0] read_byte;
    logic [1:0]        status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/tbcc_cell.sv =====
`default_nettype none

module tbcc_cell
  import tbcc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire cell_mode_e        mode_i,
  input  wire logic [BYTE_W-1:0] prev_i,
  input  wire logic [BYTE_W-1:0] next_i,
  output logic      [BYTE_W-1:0] q_o
);

  logic [BYTE_W-1:0] data_q;

  // push takes from the head side, pop from the tail side
  always_ff @(posedge clk_i) begin
    unique case (mode_i)
      CM_PUSH: data_q <= prev_i;
      CM_POP:  data_q <= next_i;
      default: data_q <= data_q;
    endcase
  end

  assign q_o = data_q;

endmodule

`default_nettype wire

// ===== design/text_buffer_cursor_clipboard_unit.sv =====
`default_nettype none

// Text buffer with cursor and clipboard. The text is held as two rows of byte
// cells whose heads meet at the cursor (characters before it, last one at the
// head, and characters after it, first one at the head), the clipboard as a
// third row. One transaction is taken at a time and answered by one result.
// Left, right and insert shift the rows by one place; cut, copy, paste and
// read turn a row once round so that it returns to its place; refused or
// empty operations leave the rows alone.
module text_buffer_cursor_clipboard_unit
  import tbcc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_item_t     out_data_o
);

  ctrl_state_e state_q, state_d;

  op_e               op_q;
  logic [BYTE_W-1:0] ch_q;
  logic [CNT_W-1:0]  n_q, d_q, k_q, last_q;
  logic              rd_left_q;
  logic [POS_W-1:0]  cursor_q, tlen_q, clen_q;
  logic [BYTE_W-1:0] rbyte_q;
  status_e           status_q;

  logic in_acc, busy_done;

  // rows of cells
  logic [BYTE_W-1:0] left_cell  [TEXT_DEPTH];
  logic [BYTE_W-1:0] right_cell [TEXT_DEPTH];
  logic [BYTE_W-1:0] clip_cell  [CLIP_DEPTH];
  cell_mode_e        left_mode, right_mode, clip_mode;
  logic [BYTE_W-1:0] left_push, left_fill, right_push, right_fill, clip_fill;
  logic [BYTE_W-1:0] left_head, right_head, clip_head;

  assign left_head  = left_cell[0];
  assign right_head = right_cell[0];
  assign clip_head  = clip_cell[0];

  for (genvar i = 0; i < TEXT_DEPTH; i++) begin : g_text
    logic [BYTE_W-1:0] l_prev, l_next, r_prev, r_next;
    if (i == 0) begin : g_first
      assign l_prev = left_push;
      assign r_prev = right_push;
    end else begin : g_mid
      assign l_prev = left_cell[i-1];
      assign r_prev = right_cell[i-1];
    end
    if (i == TEXT_DEPTH - 1) begin : g_last
      assign l_next = left_fill;
      assign r_next = right_fill;
    end else begin : g_body
      assign l_next = left_cell[i+1];
      assign r_next = right_cell[i+1];
    end
    tbcc_cell u_left (
      .clk_i, .mode_i(left_mode), .prev_i(l_prev), .next_i(l_next), .q_o(left_cell[i])
    );
    tbcc_cell u_right (
      .clk_i, .mode_i(right_mode), .prev_i(r_prev), .next_i(r_next), .q_o(right_cell[i])
    );
  end

  for (genvar j = 0; j < CLIP_DEPTH; j++) begin : g_clip
    logic [BYTE_W-1:0] c_next;
    if (j == CLIP_DEPTH - 1) begin : g_last
      assign c_next = clip_fill;
    end else begin : g_body
      assign c_next = clip_cell[j+1];
    end
    tbcc_cell u_clip (
      .clk_i, .mode_i(clip_mode), .prev_i(clip_head), .next_i(c_next), .q_o(clip_cell[j])
    );
  end

  // row control for the current step
  logic k_lt_n, k_in_text, k_in_clip;
  assign k_lt_n    = k_q < n_q;
  assign k_in_text = k_q < CNT_W'(TEXT_DEPTH);
  assign k_in_clip = k_q < CNT_W'(CLIP_DEPTH);

  always_comb begin
    left_mode  = CM_HOLD;
    right_mode = CM_HOLD;
    clip_mode  = CM_HOLD;
    left_push  = '0;
    left_fill  = left_head;
    right_push = '0;
    right_fill = right_head;
    clip_fill  = clip_head;
    if (state_q == S_BUSY) begin
      case (op_q) inside
        OP_LEFT: begin
          left_mode  = CM_POP;
          right_mode = CM_PUSH;
          right_push = left_head;
        end
        OP_RIGHT: begin
          right_mode = CM_POP;
          left_mode  = CM_PUSH;
          left_push  = right_head;
        end
        OP_INSERT: begin
          left_mode = CM_PUSH;
          left_push = ch_q;
        end
        OP_CUT, OP_COPY: begin
          if (op_q == OP_CUT) begin
            if (k_lt_n) right_mode = CM_POP;
          end else if (k_in_text) begin
            right_mode = CM_POP;
          end
          if (k_in_clip) begin
            clip_mode = CM_POP;
            clip_fill = k_lt_n ? right_head : clip_head;
          end
        end
        OP_PASTE: begin
          if (k_in_clip) clip_mode = CM_POP;
          if (k_lt_n) begin
            left_mode = CM_PUSH;
            left_push = clip_head;
          end
        end
        OP_READ: begin
          if (k_in_text) begin
            if (rd_left_q) left_mode = CM_POP;
            else right_mode = CM_POP;
          end
        end
        default: ;
      endcase
    end
  end

  // state machine
  assign in_acc    = (state_q == S_IDLE) && in_valid_i;
  assign busy_done = (state_q == S_BUSY) && (k_q == last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // decisions taken when an item arrives
  logic [POS_W-1:0] avail, cut_n, clip_room;
  logic [POS_W:0]   paste_len;
  logic             act;
  status_e          st_new;
  logic [CNT_W-1:0] last_new;

  assign avail     = tlen_q - cursor_q;
  assign clip_room = (CLIP_DEPTH > 256) ? '1 : POS_W'(CLIP_DEPTH);
  assign paste_len = {1'b0, tlen_q} + {1'b0, clen_q};

  always_comb begin
    cut_n = (in_data_i.count < avail) ? in_data_i.count : avail;
    if (cut_n > clip_room) cut_n = clip_room;
  end

  always_comb begin
    state_d  = state_q;
    act      = 1'b0;
    st_new   = ST_OK;
    last_new = CNT_W'(MAX_DEPTH - 1);
    case (op_e'(in_data_i.operation)) inside
      OP_LEFT: begin
        act      = cursor_q != '0;
        last_new = '0;
      end
      OP_RIGHT: begin
        act      = cursor_q < tlen_q;
        last_new = '0;
      end
      OP_INSERT: begin
        last_new = '0;
        if (tlen_q >= POS_W'(TEXT_DEPTH)) st_new = ST_FULL;
        else act = 1'b1;
      end
      OP_CUT, OP_COPY: act = cut_n != '0;
      OP_PASTE: begin
        if (paste_len > (POS_W+1)'(TEXT_DEPTH)) st_new = ST_FULL;
        else act = clen_q != '0;
      end
      OP_READ: begin
        if ({1'b0, in_data_i.read_index} < tlen_q) act = 1'b1;
        else st_new = ST_RANGE;
      end
      default: ;
    endcase
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = act ? S_BUSY : S_OUT;
      S_BUSY: if (busy_done) state_d = S_OUT;
      S_OUT:  if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // scalar state and result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      tlen_q   <= '0;
      clen_q   <= '0;
      k_q      <= '0;
    end else if (in_acc) begin
      k_q <= '0;
      case (op_e'(in_data_i.operation))
        OP_LEFT:  if (act) cursor_q <= cursor_q - 1'b1;
        OP_RIGHT: if (act) cursor_q <= cursor_q + 1'b1;
        OP_INSERT: begin
          if (act) begin
            cursor_q <= cursor_q + 1'b1;
            tlen_q   <= tlen_q + 1'b1;
          end
        end
        OP_CUT: begin
          clen_q <= cut_n;
          tlen_q <= tlen_q - cut_n;
        end
        OP_COPY: clen_q <= cut_n;
        OP_PASTE: begin
          if (act) begin
            cursor_q <= cursor_q + clen_q;
            tlen_q   <= tlen_q + clen_q;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_BUSY) begin
      k_q <= k_q + 1'b1;
    end
  end

  // per-item payload registers
  logic [POS_W-1:0] idx_ext;
  assign idx_ext = {1'b0, in_data_i.read_index};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= op_e'(in_data_i.operation);
      ch_q      <= in_data_i.char_in;
      last_q    <= last_new;
      status_q  <= st_new;
      rbyte_q   <= '0;
      rd_left_q <= idx_ext < cursor_q;
      d_q       <= (idx_ext < cursor_q) ? CNT_W'(cursor_q - idx_ext - 1'b1)
                                        : CNT_W'(idx_ext - cursor_q);
      n_q       <= (op_e'(in_data_i.operation) == OP_PASTE) ? CNT_W'(clen_q)
                                                           : CNT_W'(cut_n);
    end else if (state_q == S_BUSY && op_q == OP_READ && k_q == d_q) begin
      rbyte_q <= rd_left_q ? left_head : right_head;
    end
  end

  assign in_stall_o             = state_q != S_IDLE;
  assign out_valid_o            = state_q == S_OUT;
  assign out_data_o.cursor      = cursor_q;
  assign out_data_o.text_length = tlen_q;
  assign out_data_o.clip_length = clen_q;
  assign out_data_o.read_byte   = rbyte_q;
  assign out_data_o.status      = status_q;

endmodule

`default_nettype wire

// ===== design/tbcc_checker.sv =====
`default_nettype none

module tbcc_checker
  import tbcc_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");

  // an accepted transaction blocks the input next cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("input not held off");

  // cursor stays within the text
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.cursor <= out_data_o.text_length))
    else $error("cursor beyond text");

  // text never exceeds the store
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.text_length <= POS_W'(TEXT_DEPTH)))
    else $error("text length overflow");

  // a refused read returns zero
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_RANGE) |-> (out_data_o.read_byte == '0))
    else $error("out of range read returned data");

endmodule

bind text_buffer_cursor_clipboard_unit tbcc_checker u_tbcc_checker (.*);

`default_nettype wire
